// ----- rtl/aes_pkg.sv -----
// aes_pkg: shared widths, sideband type and saturation helper for the ADSR envelope pipeline.
// No dependencies.
package aes_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TIME_W    = 32;
    localparam int LVL_W     = 16;
    localparam int LVL_MAX   = (1 << (LVL_W - 1)) - 1;
    localparam int LVL_MIN   = -(1 << (LVL_W - 1));

    typedef logic signed [LVL_W-1:0] aes_lvl_t;

    typedef struct packed {
        aes_lvl_t from_lvl;
        aes_lvl_t to_lvl;
        aes_lvl_t end_lvl;
        logic     rel_pass;
        logic     rel_end;
    } aes_side_t;

    function automatic aes_lvl_t aes_sat(input logic signed [LVL_W+1:0] v);
        aes_lvl_t r;
        if (v > (LVL_W+2)'(LVL_MAX))
            r = aes_lvl_t'(LVL_MAX);
        else if (v < (LVL_W+2)'(LVL_MIN))
            r = aes_lvl_t'(LVL_MIN);
        else
            r = v[LVL_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/adsr_envelope_sample.sv -----
// adsr_envelope_sample: top level, stage select, two dividers, two interpolators.
// Depends on aes_pkg, aes_div, aes_lerp.
//
// One sample beat in per clock, one amplitude beat out per beat in, in order.
// The path runs through one select stage, FRAC_BITS divider stages (one quotient
// bit each), then the stage and release interpolators, each registering a
// multiply and then a round, add and saturate. busy is always low; done marks each
// amplitude for exactly one cycle and must be taken then.
module adsr_envelope_sample
    import aes_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [TIME_W-1:0]       held_time,
    input  logic [TIME_W-1:0]       released_time,
    input  logic [TIME_W-1:0]       attack_span,
    input  logic [TIME_W-1:0]       decay_span,
    input  logic [TIME_W-1:0]       release_span,
    input  logic signed [LVL_W-1:0] begin_level,
    input  logic signed [LVL_W-1:0] peak_level,
    input  logic signed [LVL_W-1:0] hold_level,
    input  logic signed [LVL_W-1:0] end_level,
    output logic                    done,
    output logic signed [LVL_W-1:0] amplitude
);

    logic              v0_reg;
    aes_side_t         side0_next, side0_reg;
    logic [TIME_W-1:0] num_a_next, den_a_next, num_r_next, den_r_next;
    logic [TIME_W-1:0] num_a_reg, den_a_reg, num_r_reg, den_r_reg;
    logic [TIME_W:0]   ad_sum;

    logic                 qa_v, qr_v;
    logic [FRAC_BITS-1:0] qa, qr;
    aes_side_t            side_pipe_reg [FRAC_BITS];

    aes_side_t            side_d1_reg, side_d2_reg;
    logic [FRAC_BITS-1:0] qr_d1_reg, qr_d2_reg;
    logic                 l1_v;
    aes_lvl_t             amp1;
    aes_lvl_t             r_from, r_to;

    assign busy   = 1'b0;
    assign ad_sum = {1'b0, attack_span} + {1'b0, decay_span};

    always_comb
    begin
        side0_next.end_lvl = end_level;
        num_a_next = '0;
        den_a_next = TIME_W'(1);
        if (held_time < attack_span)
        begin
            side0_next.from_lvl = begin_level;
            side0_next.to_lvl   = peak_level;
            num_a_next = held_time;
            den_a_next = attack_span;
        end
        else if ({1'b0, held_time} < ad_sum)
        begin
            side0_next.from_lvl = peak_level;
            side0_next.to_lvl   = hold_level;
            num_a_next = held_time - attack_span;
            den_a_next = decay_span;
        end
        else
        begin
            side0_next.from_lvl = hold_level;
            side0_next.to_lvl   = hold_level;
        end
        side0_next.rel_pass = (released_time == '0);
        side0_next.rel_end  = !side0_next.rel_pass && (released_time >= release_span);
        if (!side0_next.rel_pass && !side0_next.rel_end)
        begin
            num_r_next = released_time;
            den_r_next = release_span;
        end
        else
        begin
            num_r_next = '0;
            den_r_next = TIME_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        side0_reg <= side0_next;
        num_a_reg <= num_a_next;
        den_a_reg <= den_a_next;
        num_r_reg <= num_r_next;
        den_r_reg <= den_r_next;
    end

    aes_div u_div_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .num       (num_a_reg),
        .den       (den_a_reg),
        .out_valid (qa_v),
        .quot      (qa)
    );

    aes_div u_div_rel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .num       (num_r_reg),
        .den       (den_r_reg),
        .out_valid (qr_v),
        .quot      (qr)
    );

    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= side0_reg;
        for (int i = 1; i < FRAC_BITS; i++)
        begin
            side_pipe_reg[i] <= side_pipe_reg[i-1];
        end
        side_d1_reg <= side_pipe_reg[FRAC_BITS-1];
        side_d2_reg <= side_d1_reg;
        qr_d1_reg   <= qr;
        qr_d2_reg   <= qr_d1_reg;
    end

    aes_lerp u_lerp_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qa_v),
        .from_lvl  (side_pipe_reg[FRAC_BITS-1].from_lvl),
        .to_lvl    (side_pipe_reg[FRAC_BITS-1].to_lvl),
        .frac      (qa),
        .out_valid (l1_v),
        .result    (amp1)
    );

    assign r_from = side_d2_reg.rel_end ? side_d2_reg.end_lvl : amp1;
    assign r_to   = (side_d2_reg.rel_pass || side_d2_reg.rel_end) ? r_from
                                                                  : side_d2_reg.end_lvl;

    aes_lerp u_lerp_rel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l1_v),
        .from_lvl  (r_from),
        .to_lvl    (r_to),
        .frac      (qr_d2_reg),
        .out_valid (done),
        .result    (amplitude)
    );

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        qa_v == qr_v)
        else $error("dividers out of step");
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v0_reg, FRAC_BITS + 4))
        else $error("amplitude beat without sample beat");

endmodule

// ----- rtl/aes_div.sv -----
// aes_div: pipelined restoring divider, one quotient bit per stage, FRAC_BITS stages.
// Gives floor(num * 2^FRAC_BITS / den) for num < den. Depends on aes_pkg.
module aes_div
    import aes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [TIME_W-1:0]    num,
    input  logic [TIME_W-1:0]    den,
    output logic                 out_valid,
    output logic [FRAC_BITS-1:0] quot
);

    logic [TIME_W-1:0]    rem_reg  [FRAC_BITS];
    logic [TIME_W-1:0]    den_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0] q_reg    [FRAC_BITS];
    logic                 v_reg    [FRAC_BITS];

    genvar s;
    generate
        for (s = 0; s < FRAC_BITS; s++)
        begin : g_stage
            logic [TIME_W-1:0]    rem_prev;
            logic [TIME_W-1:0]    den_prev;
            logic [FRAC_BITS-1:0] q_prev;
            logic                 v_prev;
            logic [TIME_W+1:0]    diff;
            logic                 ge;

            if (s == 0)
            begin : g_first
                assign rem_prev = num;
                assign den_prev = den;
                assign q_prev   = '0;
                assign v_prev   = in_valid;
            end
            else
            begin : g_rest
                assign rem_prev = rem_reg[s-1];
                assign den_prev = den_reg[s-1];
                assign q_prev   = q_reg[s-1];
                assign v_prev   = v_reg[s-1];
            end

            assign diff = {1'b0, rem_prev, 1'b0} - {2'b00, den_prev};
            assign ge   = ~diff[TIME_W+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else
                    v_reg[s] <= v_prev;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= ge ? diff[TIME_W-1:0] : {rem_prev[TIME_W-2:0], 1'b0};
                den_reg[s] <= den_prev;
                q_reg[s]   <= {q_prev[FRAC_BITS-2:0], ge};
            end
        end
    endgenerate

    assign out_valid = v_reg[FRAC_BITS-1];
    assign quot      = q_reg[FRAC_BITS-1];

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] |-> rem_reg[0] < den_reg[0])
        else $error("divider remainder not below divisor");
    a_last_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rem_reg[FRAC_BITS-1] < den_reg[FRAC_BITS-1])
        else $error("final remainder not below divisor");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, FRAC_BITS))
        else $error("divider beat without input");

endmodule

// ----- rtl/aes_lerp.sv -----
// aes_lerp: two-stage linear interpolation, multiply then round, add and saturate.
// Depends on aes_pkg.
module aes_lerp
    import aes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  aes_lvl_t             from_lvl,
    input  aes_lvl_t             to_lvl,
    input  logic [FRAC_BITS-1:0] frac,
    output logic                 out_valid,
    output aes_lvl_t             result
);

    localparam int PW = LVL_W + FRAC_BITS + 2;

    logic signed [LVL_W:0]   delta;
    logic signed [PW-1:0]    prod_next;
    logic signed [PW-1:0]    prod_reg;
    aes_lvl_t                from_reg;
    logic                    v1_reg;
    logic signed [PW-1:0]    rounded;
    logic signed [LVL_W+1:0] step;
    logic signed [LVL_W+1:0] sum;
    aes_lvl_t                result_reg;
    logic                    v2_reg;

    assign delta     = (LVL_W+1)'(to_lvl) - (LVL_W+1)'(from_lvl);
    assign prod_next = PW'(delta) * PW'($signed({1'b0, frac}));

    assign rounded = prod_reg + PW'(1 << (FRAC_BITS - 1));
    assign step    = rounded[FRAC_BITS+LVL_W+1:FRAC_BITS];
    assign sum     = (LVL_W+2)'(from_reg) + step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        from_reg   <= from_lvl;
        result_reg <= aes_sat(sum);
    end

    assign out_valid = v2_reg;
    assign result    = result_reg;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, 2))
        else $error("interpolator beat without input");
    a_in_to_mid: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> v1_reg)
        else $error("interpolator dropped a beat at the multiply stage");
    a_mid_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> out_valid)
        else $error("interpolator dropped a beat at the round stage");

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for adsr_envelope_sample.
// Depends on aes_pkg and the adsr_envelope_sample RTL; queue-fed driver, clocked monitor.
module tb_top;
    import aes_pkg::*;

    typedef struct {
        logic [31:0] held;
        logic [31:0] rel;
        logic [31:0] att;
        logic [31:0] dec;
        logic [31:0] rsp;
        logic [15:0] lv_begin;
        logic [15:0] lv_peak;
        logic [15:0] lv_hold;
        logic [15:0] lv_end;
    } sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    logic [31:0] held_time = '0;
    logic [31:0] released_time = '0;
    logic [31:0] attack_span = '0;
    logic [31:0] decay_span = '0;
    logic [31:0] release_span = '0;
    logic signed [15:0] begin_level = '0;
    logic signed [15:0] peak_level = '0;
    logic signed [15:0] hold_level = '0;
    logic signed [15:0] end_level = '0;
    logic signed [15:0] amplitude;

    sample_t pending_q[$];
    logic [15:0] amp_q[$];
    int fail_cnt = 0;
    int idle_pct = 34;
    bit feed_done = 1'b0;
    bit hold_off = 1'b0;

    adsr_envelope_sample u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .held_time(held_time), .released_time(released_time),
        .attack_span(attack_span), .decay_span(decay_span),
        .release_span(release_span), .begin_level(begin_level),
        .peak_level(peak_level), .hold_level(hold_level),
        .end_level(end_level), .done(done), .amplitude(amplitude)
    );

    always #5 clk = ~clk;

    function automatic longint interp(longint from, longint to, longint e, longint span);
        longint f, p, q, r;
        if (span == 0 || e >= span)
            return to;
        f = (e << FRAC_BITS) / span;
        p = (to - from) * f + (longint'(1) << (FRAC_BITS - 1));
        q = p >>> FRAC_BITS;
        r = from + q;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic logic [15:0] envelope_of(sample_t s);
        longint held, att, dec, amp;
        held = s.held;
        att = s.att;
        dec = s.dec;
        if (held < att)
            amp = interp(longint'($signed(s.lv_begin)), longint'($signed(s.lv_peak)), held, att);
        else if (held < att + dec)
            amp = interp(longint'($signed(s.lv_peak)), longint'($signed(s.lv_hold)),
                         held - att, dec);
        else
            amp = longint'($signed(s.lv_hold));
        if (s.rel != 0)
        begin
            if (s.rel >= s.rsp)
                amp = longint'($signed(s.lv_end));
            else
                amp = interp(amp, longint'($signed(s.lv_end)), longint'(s.rel),
                             longint'(s.rsp));
        end
        return amp[15:0];
    endfunction

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] rand_lvl();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        s.att = rand_time();
        s.dec = rand_time();
        s.rsp = rand_time();
        case ($urandom_range(0, 3))
            0: s.held = 32'({1'b0, $urandom_range(0, 32'hFFFF)} % ({1'b0, s.att} + 33'd1));
            1: s.held = 32'({1'b0, s.att} + ({1'b0, $urandom()} % ({1'b0, s.dec} + 33'd1)));
            default: s.held = rand_time();
        endcase
        case ($urandom_range(0, 3))
            0: s.rel = 32'd0;
            1: s.rel = 32'({1'b0, $urandom()} % ({1'b0, s.rsp} + 33'd1));
            default: s.rel = rand_time();
        endcase
        s.lv_begin = rand_lvl();
        s.lv_peak = rand_lvl();
        s.lv_hold = rand_lvl();
        s.lv_end = rand_lvl();
        return s;
    endfunction

    function automatic sample_t mk(logic [31:0] h, logic [31:0] r, logic [31:0] a,
                                   logic [31:0] d, logic [31:0] rs, logic [15:0] b,
                                   logic [15:0] p, logic [15:0] sl, logic [15:0] e);
        sample_t s;
        s.held = h; s.rel = r; s.att = a; s.dec = d; s.rsp = rs;
        s.lv_begin = b; s.lv_peak = p; s.lv_hold = sl; s.lv_end = e;
        return s;
    endfunction

    // driver
    always @(negedge clk)
    begin
        sample_t s;
        if (rst_n && !(start && busy))
        begin
            if (!hold_off && pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                s = pending_q.pop_front();
                held_time <= s.held;
                released_time <= s.rel;
                attack_span <= s.att;
                decay_span <= s.dec;
                release_span <= s.rsp;
                begin_level <= s.lv_begin;
                peak_level <= s.lv_peak;
                hold_level <= s.lv_hold;
                end_level <= s.lv_end;
                amp_q.push_back(envelope_of(s));
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic [15:0] want;
        if (rst_n && done)
        begin
            if (amp_q.size() == 0)
            begin
                $error("amplitude: unexpected beat, actual %0d", amplitude);
                fail_cnt++;
            end
            else
            begin
                want = amp_q.pop_front();
                if (amplitude !== want)
                begin
                    $error("amplitude: expected %0d actual %0d", $signed(want), amplitude);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        pending_q.push_back(mk(0, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h0000, 16'h1234));
        pending_q.push_back(mk(100, 0, 1000, 500, 10, 16'h8000, 16'h7FFF, 16'h4000, 0));
        pending_q.push_back(mk(999, 0, 1000, 500, 10, 16'h7FFF, 16'h8000, 16'h4000, 0));
        pending_q.push_back(mk(1200, 0, 1000, 500, 10, 0, 16'h7FFF, 16'h8000, 0));
        pending_q.push_back(mk(1500, 0, 1000, 500, 10, 0, 16'h7FFF, 16'hC000, 0));
        pending_q.push_back(mk(5, 0, 0, 10, 0, 16'h1111, 16'h7FFF, 16'h8000, 0));
        pending_q.push_back(mk(5, 0, 0, 0, 0, 16'h1111, 16'h2222, 16'h3333, 0));
        pending_q.push_back(mk(5, 0, 10, 0, 0, 16'h8000, 16'h7FFF, 16'h3333, 0));
        pending_q.push_back(mk(32'hFFFF_FFFE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                               16'h8000, 16'h7FFF, 16'h8000, 0));
        pending_q.push_back(mk(32'hFFFF_FFFF, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0,
                               16'h8000, 16'h7FFF, 16'h8000, 0));
        pending_q.push_back(mk(50, 1, 0, 0, 0, 0, 0, 16'h7FFF, 16'h8000));
        pending_q.push_back(mk(50, 5, 0, 0, 10, 0, 0, 16'h7FFF, 16'h8000));
        pending_q.push_back(mk(50, 10, 0, 0, 10, 0, 0, 16'h7FFF, 16'h8000));
        pending_q.push_back(mk(50, 32'hFFFF_FFFF, 100, 0, 32'hFFFF_FFFF, 16'h8000,
                               16'h7FFF, 0, 16'h7FFF));
        pending_q.push_back(mk(50, 32'hFFFF_FFFE, 100, 0, 32'hFFFF_FFFF, 16'h7FFF,
                               16'h8000, 0, 16'h8000));
        pending_q.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF));
        for (int i = 0; i < 350; i++) pending_q.push_back(rand_sample());
        wait (pending_q.size() == 0);
        hold_off = 1'b1;
        wait (amp_q.size() == 0);
        repeat ($urandom_range(1, 30)) @(posedge clk);
        hold_off = 1'b0;
        idle_pct = 86;
        for (int i = 0; i < 350; i++) pending_q.push_back(rand_sample());
        wait (pending_q.size() == 0);
        idle_pct = 0;
        for (int i = 0; i < 350; i++) pending_q.push_back(rand_sample());
        wait (pending_q.size() == 0);
        @(negedge clk);
        @(negedge clk);
        hold_off = 1'b1;
        wait (amp_q.size() == 0);
        repeat (40) @(posedge clk);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
